### src/abbl_pkg.sv
// ----------------------------------------------------------------------------
// abbl_pkg
// Shared types and constants for the acknowledgement burn ledger.
// ----------------------------------------------------------------------------
package abbl_pkg;

    // widest values the row cells carry, sized for the largest configuration
    localparam int IDX_W   = 6;   // row index, up to 64 rows
    localparam int BURN_W  = 4;   // per-row burn count, up to 15
    localparam int SUM_W   = 10;  // transfer sum, up to 64 * 15
    localparam int LIM_W   = 17;  // width used for the aggregate limit compare

    // result codes
    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_INVALID  = 2'd1;
    localparam logic [1:0] RC_RESOURCE = 2'd2;
    localparam logic [1:0] RC_EXPIRED  = 2'd3;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CHECK  = 2'd1;
    localparam logic [1:0] OP_CHARGE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic REG_OWNER_HANDLE = 1'b0;
    localparam logic REG_OWNER_EXPIRY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DONE
    } t_state;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        C_NONE,
        C_EXPIRE,
        C_TICK,
        C_CLEAR,
        C_INC,
        C_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] target;
    } t_cmd;

    // latched input transaction
    typedef struct packed {
        logic [63:0] handle;
        logic [15:0] frag_cnt;
        logic [15:0] bitmap;
        logic [7:0]  status;
        logic [7:0]  reason;
        logic [63:0] now;
    } t_item;

    // scan result handed from cell to cell
    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  match_idx;
        logic [BURN_W-1:0] match_burns;
        logic              match_exp;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic [SUM_W-1:0]  sum;
    } t_carry;

endpackage

### src/abbl_cell.sv
// ----------------------------------------------------------------------------
// abbl_cell
// One ledger row: holds the row state, applies broadcast commands and adds
// its contribution to the scan result passed along the chain.
// ----------------------------------------------------------------------------
module abbl_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  abbl_pkg::t_cmd   i_cmd,
    input  abbl_pkg::t_item  i_item,
    input  logic [63:0]    i_owner_handle,
    input  logic [63:0]    i_owner_expiry,
    input  abbl_pkg::t_carry i_carry,
    output abbl_pkg::t_carry o_carry
);
    import abbl_pkg::*;

    logic              r_valid;
    logic [BURN_W-1:0] r_burns;
    logic [63:0]       r_handle;
    logic [4:0]        r_frag;
    logic [15:0]       r_bitmap;
    logic [7:0]        r_status;
    logic [7:0]        r_reason;
    logic [63:0]       r_expiry;
    t_carry            r_carry;
    t_carry            n_carry;

    logic expired;
    logic handle_hit;
    logic id_hit;
    logic target_hit;

    // local compares against the latched transaction
    assign expired    = (r_expiry != 64'd0) && (i_item.now >= r_expiry);
    assign handle_hit = r_valid && (r_handle == i_item.handle);
    assign id_hit     = handle_hit && ({11'd0, r_frag} == i_item.frag_cnt)
                        && (r_bitmap == i_item.bitmap) && (r_status == i_item.status)
                        && (r_reason == i_item.reason);
    assign target_hit = (i_cmd.target == IDX_W'(CELL_IDX));

    // row control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_burns <= '0;
        end else begin
            case (i_cmd.op)
                C_EXPIRE: begin
                    if (r_valid && expired) begin
                        r_valid <= 1'b0;
                        r_burns <= '0;
                    end
                end
                C_TICK: begin
                    if (r_valid && (expired || r_handle == i_owner_handle)) begin
                        r_valid <= 1'b0;
                        r_burns <= '0;
                    end
                end
                C_CLEAR: begin
                    r_valid <= 1'b0;
                    r_burns <= '0;
                end
                C_INC: begin
                    if (target_hit) begin
                        r_burns <= r_burns + BURN_W'(1);
                    end
                end
                C_INSERT: begin
                    if (target_hit) begin
                        r_valid <= 1'b1;
                        r_burns <= BURN_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // row identity, written on insert only
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == C_INSERT && target_hit) begin
            r_handle <= i_item.handle;
            r_frag   <= i_item.frag_cnt[4:0];
            r_bitmap <= i_item.bitmap;
            r_status <= i_item.status;
            r_reason <= i_item.reason;
            r_expiry <= i_owner_expiry;
        end
    end

    // scan contribution
    always_comb begin
        n_carry = i_carry;
        if (!i_carry.match_found && id_hit) begin
            n_carry.match_found = 1'b1;
            n_carry.match_idx   = IDX_W'(CELL_IDX);
            n_carry.match_burns = r_burns;
            n_carry.match_exp   = expired;
        end
        if (!i_carry.free_found && !r_valid) begin
            n_carry.free_found = 1'b1;
            n_carry.free_idx   = IDX_W'(CELL_IDX);
        end
        if (handle_hit && i_item.handle != 64'd0) begin
            n_carry.sum = i_carry.sum + {{(SUM_W-BURN_W){1'b0}}, r_burns};
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_carry = r_carry;

endmodule

### src/ack_burn_budget_ledger_core.sv
// ----------------------------------------------------------------------------
// ack_burn_budget_ledger_core
// Acknowledgement burn ledger built as a chain of row cells.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  command   | start / busy              | i_op, i_transfer_handle, ...
//  result    | o_valid (one cycle)       | o_result_code, o_row_burns, ...
//  config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// The result strobe follows the accepting edge after the expiry step (S_PREP),
// the scan while it passes the cell chain (S_SCAN) and the decide-and-commit
// step (S_DONE); the result is registered. busy is low on the strobe cycle, so
// the next transaction can be taken then, but not before the last one is done.
// Reset is synchronous and empties the ledger at once; no clearing pass.
// The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module ack_burn_budget_ledger_core #(
    parameter int LEDGER_ROWS    = 8,
    parameter int BURN_MAX       = 2,
    parameter int AGGREGATE_MAX  = 32,
    parameter int FRAG_COUNT_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_transfer_handle,
    input  logic [15:0] i_frag_count,
    input  logic [15:0] i_received_bitmap,
    input  logic [7:0]  i_ack_status,
    input  logic [7:0]  i_ack_reason,
    input  logic [63:0] i_now,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_result_code,
    output logic [1:0]  o_row_burns,
    output logic [4:0]  o_transfer_burns
);
    import abbl_pkg::*;

    localparam int CNT_W = $clog2(LEDGER_ROWS);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [1:0]        r_op;
    t_item             r_item;
    logic [63:0]       r_owner_handle;
    logic [63:0]       r_owner_expiry;
    logic              r_valid;
    logic [1:0]        r_code;
    logic [1:0]        r_rb;
    logic [4:0]        r_tb;
    t_cmd              cmd;
    t_carry            carry [LEDGER_ROWS+1];

    logic              id_ok;
    logic              own_exp;
    logic [LIM_W-1:0]  lim;
    logic [LIM_W-1:0]  dbl;
    logic [1:0]        chk_code;
    logic [1:0]        n_code;
    logic              do_inc;
    logic              do_ins;
    logic [BURN_W-1:0] burns_after;
    logic [SUM_W:0]    sum_after;

    // identity and owner tests on the latched transaction
    assign id_ok   = (r_item.handle != 64'd0) && (r_item.handle != '1)
                     && (r_item.frag_cnt >= 16'd2)
                     && (r_item.frag_cnt <= 16'(FRAG_COUNT_MAX));
    assign own_exp = (r_owner_expiry != 64'd0) && (r_item.now >= r_owner_expiry);
    assign dbl     = {r_item.frag_cnt, 1'b0};
    assign lim     = (dbl > LIM_W'(AGGREGATE_MAX)) ? LIM_W'(AGGREGATE_MAX) : dbl;

    // burn check from the scan result at the chain tail
    always_comb begin
        if (!id_ok) begin
            chk_code = RC_INVALID;
        end else if (own_exp && (r_owner_handle == 64'd0
                                 || r_owner_handle == r_item.handle)) begin
            chk_code = RC_EXPIRED;
        end else if (carry[LEDGER_ROWS].match_found && carry[LEDGER_ROWS].match_exp) begin
            chk_code = RC_EXPIRED;
        end else if (carry[LEDGER_ROWS].match_found
                     && carry[LEDGER_ROWS].match_burns >= BURN_W'(BURN_MAX)) begin
            chk_code = RC_RESOURCE;
        end else if ({{(LIM_W-SUM_W){1'b0}}, carry[LEDGER_ROWS].sum} >= lim) begin
            chk_code = RC_RESOURCE;
        end else begin
            chk_code = RC_OK;
        end
    end

    // decide the commit and the result
    always_comb begin
        do_inc = 1'b0;
        do_ins = 1'b0;
        n_code = RC_OK;
        if (r_op == OP_CHECK) begin
            n_code = chk_code;
        end else if (r_op == OP_CHARGE) begin
            n_code = chk_code;
            if (chk_code == RC_OK) begin
                if (carry[LEDGER_ROWS].match_found) begin
                    do_inc = 1'b1;
                end else if (carry[LEDGER_ROWS].free_found) begin
                    do_ins = 1'b1;
                end else begin
                    n_code = RC_RESOURCE;
                end
            end
        end
        burns_after = do_ins ? BURN_W'(1)
                    : carry[LEDGER_ROWS].match_burns + BURN_W'(do_inc);
        sum_after   = {1'b0, carry[LEDGER_ROWS].sum} + (SUM_W+1)'(do_inc || do_ins);
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and cell commands
    always_comb begin
        n_state    = r_state;
        cmd.op     = C_NONE;
        cmd.target = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_SCAN;
                case (r_op)
                    OP_TICK:   cmd.op = own_exp ? C_TICK : C_EXPIRE;
                    OP_CHARGE: cmd.op = id_ok ? C_EXPIRE : C_NONE;
                    OP_CLEAR:  cmd.op = C_CLEAR;
                    default:   cmd.op = C_NONE;
                endcase
            end
            S_SCAN: begin
                if (r_cnt == CNT_W'(LEDGER_ROWS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                if (do_inc) begin
                    cmd.op     = C_INC;
                    cmd.target = carry[LEDGER_ROWS].match_idx;
                end else if (do_ins) begin
                    cmd.op     = C_INSERT;
                    cmd.target = carry[LEDGER_ROWS].free_idx;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // scan cycle counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else begin
            r_cnt <= '0;
        end
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (start && r_state == S_IDLE) begin
            r_op              <= i_op;
            r_item.handle     <= i_transfer_handle;
            r_item.frag_cnt   <= i_frag_count;
            r_item.bitmap     <= i_received_bitmap;
            r_item.status     <= i_ack_status;
            r_item.reason     <= i_ack_reason;
            r_item.now        <= i_now;
        end
    end

    // owner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_handle <= '0;
            r_owner_expiry <= '0;
        end else if (r_state == S_PREP && r_op == OP_CLEAR) begin
            r_owner_handle <= '0;
            r_owner_expiry <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OWNER_HANDLE: r_owner_handle <= i_cfg_data;
                REG_OWNER_EXPIRY: r_owner_expiry <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_code <= n_code;
            if (id_ok && (carry[LEDGER_ROWS].match_found || do_ins)) begin
                r_rb <= (burns_after > BURN_W'(3)) ? 2'd3 : burns_after[1:0];
            end else begin
                r_rb <= 2'd0;
            end
            r_tb <= (sum_after > (SUM_W+1)'(31)) ? 5'd31 : sum_after[4:0];
        end
    end

    assign o_valid          = r_valid;
    assign o_result_code    = r_code;
    assign o_row_burns      = r_rb;
    assign o_transfer_burns = r_tb;

    // chain of row cells
    assign carry[0] = '0;

    for (genvar g = 0; g < LEDGER_ROWS; g++) begin : g_cell
        abbl_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd),
            .i_item         (r_item),
            .i_owner_handle (r_owner_handle),
            .i_owner_expiry (r_owner_expiry),
            .i_carry        (carry[g]),
            .o_carry        (carry[g+1])
        );
    end

endmodule

### src/abbl_checker.sv
// ----------------------------------------------------------------------------
// abbl_checker
// Port-level assertions for the ledger core, bound to the top level.
// ----------------------------------------------------------------------------
module abbl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_result_code,
    input logic [1:0] o_row_burns
);
    import abbl_pkg::*;

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // a result strobe never repeats back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result without a transaction in flight");

    // an invalid identity matches no row
    a_invalid_no_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_code == RC_INVALID) |-> (o_row_burns == 2'd0))
        else $error("invalid identity reported a row count");

endmodule

bind ack_burn_budget_ledger_core abbl_checker u_abbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_result_code (o_result_code),
    .o_row_burns   (o_row_burns)
);

### dv/ack_burn_budget_ledger_core_tb.sv
// ----------------------------------------------------------------------------
// ack_burn_budget_ledger_core_tb
// Self-checking bench for the acknowledgement burn ledger. A clocked driver
// issues queued transactions over start/busy, a clocked monitor compares
// every result strobe against a ledger model kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ack_burn_budget_ledger_core_tb;
    import abbl_pkg::*;

    localparam int ROWS     = 8;
    localparam int BURNS    = 2;
    localparam int AGG      = 32;
    localparam int FRAG_MAX = 16;
    localparam int LATENCY  = ROWS + 3;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] handle;
        logic [15:0] frag;
        logic [15:0] bitmap;
        logic [7:0]  status;
        logic [7:0]  reason;
        logic [63:0] now;
    } t_txn;

    typedef struct {
        logic [1:0] code;
        logic [1:0] rburns;
        logic [4:0] tburns;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [63:0] i_transfer_handle = '0;
    logic [15:0] i_frag_count = '0;
    logic [15:0] i_received_bitmap = '0;
    logic [7:0]  i_ack_status = '0;
    logic [7:0]  i_ack_reason = '0;
    logic [63:0] i_now = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    logic [1:0]  o_result_code;
    logic [1:0]  o_row_burns;
    logic [4:0]  o_transfer_burns;

    ack_burn_budget_ledger_core dut (.*);

    always #5 i_clk = ~i_clk;

    // ledger model state
    logic [63:0] m_owner_handle, m_owner_expiry;
    logic        m_valid [ROWS];
    logic [63:0] m_handle [ROWS];
    logic [4:0]  m_frag [ROWS];
    logic [15:0] m_bitmap [ROWS];
    logic [7:0]  m_status [ROWS];
    logic [7:0]  m_reason [ROWS];
    logic [3:0]  m_burns [ROWS];
    logic [63:0] m_expiry [ROWS];

    t_txn     pending_txns[$];
    t_outcome outcomes_due[$];
    int       idle_pct = 0;
    int       mismatches = 0;
    bit       draining = 1'b0;

    function automatic bit lapsed(logic [63:0] deadline, logic [63:0] now);
        return deadline != 0 && now >= deadline;
    endfunction

    function automatic bit identity_good(logic [63:0] h, logic [15:0] fc);
        return h != 0 && h != '1 && fc >= 2 && fc <= FRAG_MAX;
    endfunction

    function automatic int locate_row(t_txn t);
        for (int i = 0; i < ROWS; i++)
            if (m_valid[i] && m_handle[i] == t.handle && m_frag[i] == t.frag
                && m_bitmap[i] == t.bitmap && m_status[i] == t.status
                && m_reason[i] == t.reason)
                return i;
        return -1;
    endfunction

    function automatic int handle_total(logic [63:0] h);
        int s;
        s = 0;
        if (h == 0) return 0;
        for (int i = 0; i < ROWS; i++)
            if (m_valid[i] && m_handle[i] == h) s += m_burns[i];
        return s;
    endfunction

    function automatic void drop_lapsed_rows(logic [63:0] now);
        for (int i = 0; i < ROWS; i++)
            if (m_valid[i] && lapsed(m_expiry[i], now)) begin
                m_valid[i] = 1'b0;
                m_burns[i] = 0;
            end
    endfunction

    function automatic logic [1:0] judge_burn(t_txn t);
        int r, used, lim;
        used = 0;
        if (!identity_good(t.handle, t.frag)) return RC_INVALID;
        if (lapsed(m_owner_expiry, t.now)
            && (m_owner_handle == 0 || m_owner_handle == t.handle))
            return RC_EXPIRED;
        r = locate_row(t);
        if (r >= 0) begin
            if (lapsed(m_expiry[r], t.now)) return RC_EXPIRED;
            used = m_burns[r];
        end
        if (used >= BURNS) return RC_RESOURCE;
        lim = t.frag * 2;
        if (lim > AGG) lim = AGG;
        if (handle_total(t.handle) >= lim) return RC_RESOURCE;
        return RC_OK;
    endfunction

    function automatic t_outcome ledger_apply(t_txn t);
        t_outcome o;
        int r, tb;
        o.code = RC_OK;
        o.rburns = 0;
        case (t.op)
            OP_TICK: begin
                drop_lapsed_rows(t.now);
                if (lapsed(m_owner_expiry, t.now))
                    for (int i = 0; i < ROWS; i++)
                        if (m_valid[i] && m_handle[i] == m_owner_handle) begin
                            m_valid[i] = 1'b0;
                            m_burns[i] = 0;
                        end
            end
            OP_CHECK: o.code = judge_burn(t);
            OP_CHARGE: begin
                if (!identity_good(t.handle, t.frag)) o.code = RC_INVALID;
                else begin
                    drop_lapsed_rows(t.now);
                    o.code = judge_burn(t);
                    if (o.code == RC_OK) begin
                        r = locate_row(t);
                        if (r < 0) begin
                            for (int i = 0; i < ROWS && r < 0; i++)
                                if (!m_valid[i]) r = i;
                            if (r >= 0) begin
                                m_valid[r] = 1'b1;
                                m_handle[r] = t.handle;
                                m_frag[r] = t.frag[4:0];
                                m_bitmap[r] = t.bitmap;
                                m_status[r] = t.status;
                                m_reason[r] = t.reason;
                                m_burns[r] = 0;
                                m_expiry[r] = m_owner_expiry;
                            end
                        end
                        if (r < 0 || m_burns[r] >= BURNS) o.code = RC_RESOURCE;
                        else m_burns[r] = m_burns[r] + 1;
                    end
                end
            end
            default: begin
                for (int i = 0; i < ROWS; i++) begin
                    m_valid[i] = 1'b0;
                    m_burns[i] = 0;
                end
                m_owner_handle = 0;
                m_owner_expiry = 0;
            end
        endcase
        if (identity_good(t.handle, t.frag)) begin
            r = locate_row(t);
            if (r >= 0) o.rburns = (m_burns[r] > 3) ? 2'd3 : m_burns[r][1:0];
        end
        tb = handle_total(t.handle);
        o.tburns = (tb > 31) ? 5'd31 : tb[4:0];
        return o;
    endfunction

    // driver: one transaction at a time, idles at random between them
    always @(negedge i_clk) begin
        if (!i_rst_n || draining) begin
            start <= 1'b0;
        end else if (start) begin
            // previous transaction was taken at the last rising edge
            start <= 1'b0;
        end else if (outcomes_due.size() == 0 && pending_txns.size() > 0
                     && $urandom_range(99) >= idle_pct && !busy) begin
            t_txn t;
            t = pending_txns.pop_front();
            outcomes_due.push_back(ledger_apply(t));
            i_op <= t.op;
            i_transfer_handle <= t.handle;
            i_frag_count <= t.frag;
            i_received_bitmap <= t.bitmap;
            i_ack_status <= t.status;
            i_ack_reason <= t.reason;
            i_now <= t.now;
            start <= 1'b1;
        end
    end

    // monitor: compare every result strobe with the oldest outcome due
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (outcomes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result code=%0d row=%0d xfer=%0d",
                             o_result_code, o_row_burns, o_transfer_burns);
            end else begin
                t_outcome e;
                e = outcomes_due.pop_front();
                if (o_result_code !== e.code || o_row_burns !== e.rburns
                    || o_transfer_burns !== e.tburns) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 e.code, e.rburns, e.tburns, o_result_code,
                                 o_row_burns, o_transfer_burns);
                end
            end
        end
    end

    task automatic cfg_write(logic idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_OWNER_HANDLE) m_owner_handle = data;
        else m_owner_expiry = data;
    endtask

    task automatic wait_quiet();
        while (pending_txns.size() > 0 || outcomes_due.size() > 0 || start)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic queue_txn(logic [1:0] op, logic [63:0] h, logic [15:0] fc,
                             logic [15:0] bm, logic [7:0] st, logic [7:0] rs,
                             logic [63:0] now);
        t_txn t;
        t.op = op; t.handle = h; t.frag = fc; t.bitmap = bm;
        t.status = st; t.reason = rs; t.now = now;
        pending_txns.push_back(t);
    endtask

    // random sequence drawn mostly from a small handle pool so rows collide
    task automatic queue_random(int n);
        logic [63:0] pool [4];
        logic [63:0] h, now;
        logic [15:0] fc;
        int sel;
        pool[0] = 64'h1; pool[1] = 64'h2;
        pool[2] = {$urandom, $urandom}; pool[3] = 64'hFFFF_FFFF_FFFF_FFFE;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            h = (sel < 85) ? pool[$urandom_range(3)]
                : (sel < 90) ? 64'h0 : (sel < 94) ? '1 : {$urandom, $urandom};
            fc = ($urandom_range(9) == 0) ? 16'($urandom)
                 : 16'($urandom_range(FRAG_MAX, 2));
            now = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                  : 64'($urandom_range(300));
            sel = $urandom_range(99);
            queue_txn((sel < 55) ? OP_CHARGE : (sel < 80) ? OP_CHECK
                      : (sel < 97) ? OP_TICK : OP_CLEAR,
                      h, fc,
                      ($urandom_range(3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(1)),
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'h0,
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'h0, now);
        end
    endtask

    // run limit
    initial begin
        #20ms;
        $display("ack_burn_budget_ledger_core_tb: errors");
        $finish;
    end

    initial begin
        m_owner_handle = 0;
        m_owner_expiry = 0;
        for (int i = 0; i < ROWS; i++) begin
            m_valid[i] = 1'b0;
            m_burns[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: limits, invalid identities, table full, tick, clear
        idle_pct = 25;
        queue_txn(OP_CHECK, 64'h0, 16'd4, 16'h0, 8'h0, 8'h0, 64'd1);
        queue_txn(OP_CHARGE, '1, 16'd4, 16'h0, 8'h0, 8'h0, 64'd1);
        queue_txn(OP_CHARGE, 64'h5, 16'd1, 16'h0, 8'h0, 8'h0, 64'd1);
        queue_txn(OP_CHARGE, 64'h5, 16'd17, 16'h0, 8'h0, 8'h0, 64'd1);
        queue_txn(OP_CHARGE, 64'h5, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, '1);
        queue_txn(OP_CHARGE, 64'h5, 16'd2, 16'hFFFF, 8'hFF, 8'hFF, '1);
        queue_txn(OP_CHARGE, 64'h5, 16'd2, 16'hFFFF, 8'hFF, 8'hFF, '1);
        queue_txn(OP_CHARGE, 64'h5, 16'd2, 16'hFFFF, 8'hFF, 8'hFF, '1);
        queue_txn(OP_CHARGE, 64'h5, 16'd2, 16'h1, 8'h0, 8'h0, 64'd0);
        queue_txn(OP_CHARGE, 64'h5, 16'd2, 16'h2, 8'h0, 8'h0, 64'd0);
        for (int i = 0; i < 8; i++)
            queue_txn(OP_CHARGE, 64'h100 + i, 16'd16, 16'(i), 8'h0, 8'h0, 64'd0);
        queue_txn(OP_CHECK, 64'h5, 16'd2, 16'hFFFF, 8'hFF, 8'hFF, 64'd0);
        queue_txn(OP_TICK, 64'h0, 16'd0, 16'h0, 8'h0, 8'h0, '1);
        queue_txn(OP_CLEAR, 64'h5, 16'd2, 16'hFFFF, 8'hFF, 8'hFF, 64'd0);
        wait_quiet();

        // owner with deadline: row and owner expiry
        cfg_write(REG_OWNER_HANDLE, 64'h1);
        cfg_write(REG_OWNER_EXPIRY, 64'd100);
        queue_txn(OP_CHARGE, 64'h1, 16'd8, 16'h0, 8'h0, 8'h0, 64'd10);
        queue_txn(OP_CHARGE, 64'h2, 16'd8, 16'h0, 8'h0, 8'h0, 64'd10);
        queue_txn(OP_CHECK, 64'h1, 16'd8, 16'h0, 8'h0, 8'h0, 64'd100);
        queue_txn(OP_CHECK, 64'h2, 16'd8, 16'h0, 8'h0, 8'h0, 64'd150);
        queue_txn(OP_TICK, 64'h0, 16'd0, 16'h0, 8'h0, 8'h0, 64'd99);
        queue_txn(OP_TICK, 64'h0, 16'd0, 16'h0, 8'h0, 8'h0, 64'd100);
        queue_random(150);
        wait_quiet();

        // extreme owner settings, sender now idle much more
        idle_pct = 46;
        cfg_write(REG_OWNER_HANDLE, '1);
        cfg_write(REG_OWNER_EXPIRY, '1);
        queue_random(150);
        wait_quiet();

        cfg_write(REG_OWNER_HANDLE, 64'h0);
        cfg_write(REG_OWNER_EXPIRY, 64'd200);
        queue_random(150);
        wait_quiet();

        // no idling, no deadline
        idle_pct = 0;
        cfg_write(REG_OWNER_HANDLE, 64'h2);
        cfg_write(REG_OWNER_EXPIRY, 64'h0);
        queue_random(150);
        wait_quiet();
        draining = 1'b1;

        if (mismatches == 0)
            $display("ack_burn_budget_ledger_core_tb: clean");
        else
            $display("ack_burn_budget_ledger_core_tb: errors");
        $finish;
    end

endmodule

### filelist.f
src/abbl_pkg.sv
src/abbl_cell.sv
src/ack_burn_budget_ledger_core.sv
src/abbl_checker.sv
dv/ack_burn_budget_ledger_core_tb.sv
